/* rtl/core/lsm_pkg.sv */
// ----------------------------------------------------------------------------
// lsm_pkg
// Shared constants for the log-softmax unit: fixed-point formats, the
// exponential step table and the ln 2 scale factor.
// ----------------------------------------------------------------------------
`default_nettype none

package lsm_pkg;

    // operand and product widths of the shared multiplier
    localparam int MulW  = 32;
    localparam int ProdW = 64;

    // q30 one and ln 2 in q30
    localparam logic [63:0] Q30One = 64'd1073741824;
    localparam logic [31:0] Ln2Q30 = 32'd744261118;

    // number of exponent bits handled by the exp table, fraction bits of log2
    localparam int ExpBits  = 12;
    localparam int FracBits = 16;

    typedef logic [31:0] t_word;

    // q30 values of exp(-2^b / 256) for b = 0..11
    localparam t_word ExpTab [ExpBits] = '{
        32'd1069555701, 32'd1065385899, 32'd1057095000, 32'd1040706261,
        32'd1008687096, 32'd947573834,  32'd836230973,  32'd651257337,
        32'd395007542,  32'd145315154,  32'd19666268,   32'd360200
    };

endpackage

`default_nettype wire

/* rtl/core/lsm_store.sv */
// ----------------------------------------------------------------------------
// lsm_store
// Element memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [15:0]       i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [15:0]       o_rd_data
);

    logic [15:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/core/lsm_mul.sv */
// ----------------------------------------------------------------------------
// lsm_mul
// Shared unsigned 32x32 multiplier used for the exp steps, the log2
// squarings and the final ln 2 scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_mul (
    input  wire logic [lsm_pkg::MulW-1:0]  i_a,
    input  wire logic [lsm_pkg::MulW-1:0]  i_b,
    output logic      [lsm_pkg::ProdW-1:0] o_prod
);

    // full-width product
    assign o_prod = lsm_pkg::ProdW'(i_a) * lsm_pkg::ProdW'(i_b);

endmodule

`default_nettype wire

/* rtl/core/log_softmax_unit.sv */
// ----------------------------------------------------------------------------
// log_softmax_unit
// Log-softmax over a vector of signed Q7.8 samples using one shared multiplier.
// ----------------------------------------------------------------------------
// Samples load one per cycle while busy is low; a beat with final_flag high
// starts the evaluation and raises busy. Each stored element then goes through
// exp evaluation (read, 12 table steps on the shared multiplier, accumulate).
// Unless the sum is below one, its ln follows: normalization, one squaring per
// fraction bit and a final ln 2 scaling. Each element is then read back and
// output. Results come out one per strobe in load order and must be taken in
// that cycle: the unit cannot be stalled. end_of_run marks the last result,
// and busy drops in the cycle that result is presented.
// Samples past MAX_ELEMENTS are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module log_softmax_unit #(
    parameter int MAX_ELEMENTS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] i_sample,
    input  wire logic               i_final_flag,
    output logic                    o_strobe,
    output logic signed [15:0]      o_log_prob,
    output logic                    o_end_of_run
);

    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EXP_RD  = 4'd1;
    localparam logic [3:0] S_EXP_LD  = 4'd2;
    localparam logic [3:0] S_EXP_MUL = 4'd3;
    localparam logic [3:0] S_EXP_ACC = 4'd4;
    localparam logic [3:0] S_NORM    = 4'd5;
    localparam logic [3:0] S_SQR     = 4'd6;
    localparam logic [3:0] S_LOG     = 4'd7;
    localparam logic [3:0] S_OUT_RD  = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic signed [15:0] r_max, n_max;
    logic [ADDR_W-1:0] r_k, n_k;
    logic [31:0]       r_sum, n_sum;
    logic [11:0]       r_n, n_n;
    logic              r_big, n_big;
    logic [3:0]        r_bit, n_bit;
    logic [30:0]       r_acc, n_acc;
    logic [31:0]       r_m, n_m;
    logic [4:0]        r_p, n_p;
    logic [15:0]       r_frac, n_frac;
    logic [15:0]       r_lnv, n_lnv;
    logic              r_strobe, n_strobe;
    logic signed [15:0] r_log_prob, n_log_prob;
    logic              r_eor, n_eor;

    logic              accept;
    logic              wr_en;
    logic [15:0]       rd_data;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       prod;
    logic [63:0]       exp_step;
    logic [63:0]       sq;
    logic [63:0]       ln_round;
    logic [19:0]       lg;
    logic [16:0]       diff;
    logic [31:0]       exp_q16;
    logic [31:0]       sum_next;
    logic signed [17:0] y;
    logic [CNT_W-1:0]  k_inc;
    logic              k_last;

    assign accept = start && (r_state == S_IDLE);
    assign wr_en  = accept && (r_count < CNT_W'(MAX_ELEMENTS));

    lsm_store #(
        .DEPTH  (MAX_ELEMENTS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (i_sample),
        .i_rd_addr (r_k),
        .o_rd_data (rd_data)
    );

    // operand select for the shared multiplier
    always_comb begin
        lg = 20'({r_p - 5'd16, 16'd0}) + 20'(r_frac);
        unique case (r_state)
            S_EXP_MUL: begin
                mul_a = 32'(r_acc);
                mul_b = lsm_pkg::ExpTab[r_bit];
            end
            S_SQR: begin
                mul_a = r_m;
                mul_b = r_m;
            end
            default: begin
                mul_a = 32'(lg);
                mul_b = lsm_pkg::Ln2Q30;
            end
        endcase
    end

    lsm_mul u_mul (
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // datapath terms
    always_comb begin
        exp_step = (prod + (lsm_pkg::Q30One >> 1)) >> 30;
        sq       = prod >> 30;
        ln_round = (prod + 64'h20_0000_0000) >> 38;
        diff     = 17'(signed'({r_max[15], r_max})) - 17'(signed'({rd_data[15], rd_data}));
        exp_q16  = r_big ? 32'd0 : 32'((32'(r_acc) + 32'd8192) >> 14);
        sum_next = r_sum + exp_q16;
        y        = 18'(signed'(rd_data)) - 18'(r_max) - signed'(18'(r_lnv));
        k_inc    = CNT_W'(r_k) + CNT_W'(1);
        k_last   = (k_inc == r_count);
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_max      = r_max;
        n_k        = r_k;
        n_sum      = r_sum;
        n_n        = r_n;
        n_big      = r_big;
        n_bit      = r_bit;
        n_acc      = r_acc;
        n_m        = r_m;
        n_p        = r_p;
        n_frac     = r_frac;
        n_lnv      = r_lnv;
        n_strobe   = 1'b0;
        n_log_prob = r_log_prob;
        n_eor      = r_eor;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (wr_en) begin
                        n_count = r_count + CNT_W'(1);
                        if (i_sample > r_max) begin
                            n_max = i_sample;
                        end
                    end
                    if (i_final_flag) begin
                        n_k     = '0;
                        n_sum   = '0;
                        n_state = S_EXP_RD;
                    end
                end
            end
            S_EXP_RD: begin
                n_state = S_EXP_LD;
            end
            S_EXP_LD: begin
                n_n     = diff[11:0];
                n_big   = |diff[16:12];
                n_acc   = 31'(lsm_pkg::Q30One);
                n_bit   = '0;
                n_state = S_EXP_MUL;
            end
            S_EXP_MUL: begin
                if (r_n[r_bit]) begin
                    n_acc = exp_step[30:0];
                end
                n_bit = r_bit + 4'd1;
                if (r_bit == 4'(lsm_pkg::ExpBits - 1)) begin
                    n_state = S_EXP_ACC;
                end
            end
            S_EXP_ACC: begin
                n_sum = sum_next;
                if (k_last) begin
                    n_m     = sum_next;
                    n_p     = 5'd30;
                    n_state = S_NORM;
                end else begin
                    n_k     = r_k + ADDR_W'(1);
                    n_state = S_EXP_RD;
                end
            end
            S_NORM: begin
                if (r_sum < 32'd65536) begin
                    n_lnv   = '0;
                    n_k     = '0;
                    n_state = S_OUT_RD;
                end else if (r_m[30]) begin
                    n_bit   = '0;
                    n_frac  = '0;
                    n_state = S_SQR;
                end else begin
                    n_m = r_m << 1;
                    n_p = r_p - 5'd1;
                end
            end
            S_SQR: begin
                n_bit = r_bit + 4'd1;
                if (sq[31]) begin
                    n_frac = {r_frac[14:0], 1'b1};
                    n_m    = sq[32:1];
                end else begin
                    n_frac = {r_frac[14:0], 1'b0};
                    n_m    = sq[31:0];
                end
                if (r_bit == 4'(lsm_pkg::FracBits - 1)) begin
                    n_state = S_LOG;
                end
            end
            S_LOG: begin
                n_lnv   = ln_round[15:0];
                n_k     = '0;
                n_state = S_OUT_RD;
            end
            S_OUT_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                n_strobe   = 1'b1;
                n_log_prob = (y < -18'sd32768) ? 16'sh8000 : y[15:0];
                n_eor      = k_last;
                if (k_last) begin
                    n_count = '0;
                    n_max   = 16'sh8000;
                    n_sum   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + ADDR_W'(1);
                    n_state = S_OUT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_max    <= 16'sh8000;
            r_sum    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_max    <= n_max;
            r_sum    <= n_sum;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_n        <= n_n;
        r_big      <= n_big;
        r_bit      <= n_bit;
        r_acc      <= n_acc;
        r_m        <= n_m;
        r_p        <= n_p;
        r_frac     <= n_frac;
        r_lnv      <= n_lnv;
        r_log_prob <= n_log_prob;
        r_eor      <= n_eor;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_log_prob   = r_log_prob;
    assign o_end_of_run = r_eor;

endmodule

`default_nettype wire
